### sv/bfpa_pkg.sv
// Shared types, constants and controller/datapath interface of the partition allocator.
package bfpa_pkg;

    localparam int ADDR_W = 33;
    localparam int LEN_W  = 34;

    // Largest managed memory size in bytes
    localparam logic [LEN_W-1:0] MEM_MAX = 34'h2_0000_0000;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // One partition table entry
    typedef struct packed {
        logic              busy;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
    } entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       init;      // write entry 0 as one free partition
        logic       take;      // capture the request
        logic       scan_clr;  // clear the scan result
        logic       rd_en;     // read the table
        logic       scan;      // evaluate the read entry
        logic       cap_next;  // keep the read entry as right neighbour
        logic       mv;        // write the read entry to the move address
        logic       wr_rem;    // write the free remainder after the best fit
        logic       wr_grant;  // write the granted partition
        logic       wr_merge;  // write the merged free partition
        logic       resp;      // load the result register
        logic [2:0] code;      // result status
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       found;
        logic       exact;
        logic       size_zero;
        logic       is_free;
        logic [1:0] k;         // entries removed by a merge
        logic       out_full;
    } dp_stat_t;

endpackage

### sv/bfpa_datapath.sv
// Datapath: partition table memory, scan evaluation, entry updates and result register.
module bfpa_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int IW = $clog2(TABLE_DEPTH),
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bfpa_pkg::dp_cmd_t             cmd,
    input  logic [IW-1:0]                 rd_addr,
    input  logic [IW-1:0]                 mv_addr,
    input  logic [CW-1:0]                 cnt,
    output bfpa_pkg::dp_stat_t            stat,
    output logic [IW-1:0]                 best_idx,
    output logic [IW-1:0]                 lo_idx,
    input  logic                          cfg_valid,
    input  logic [bfpa_pkg::LEN_W-1:0]    cfg_data,
    input  logic [71:0]                   s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata
);

    bfpa_pkg::entry_t mem [TABLE_DEPTH];
    bfpa_pkg::entry_t rd_data_reg;
    bfpa_pkg::entry_t wr_data;
    logic [IW-1:0]    wr_addr;
    logic             wr_en;

    logic [bfpa_pkg::LEN_W-1:0]  total_reg;
    logic                        type_reg;
    logic [bfpa_pkg::LEN_W-1:0]  size_reg;
    logic [bfpa_pkg::ADDR_W-1:0] addr_reg;

    logic          scan_d_reg, cap_d_reg, mv_d_reg;
    logic [IW-1:0] rd_idx_reg, mv_addr_reg;

    logic                        found_reg, pf_reg, nf_reg;
    logic [IW-1:0]               best_reg;
    logic [bfpa_pkg::LEN_W-1:0]  best_len_reg;
    logic [bfpa_pkg::ADDR_W-1:0] best_start_reg;
    bfpa_pkg::entry_t            last_reg, prev_reg, cur_reg, next_reg;

    logic                        m_valid_reg;
    logic [47:0]                 m_data_reg;

    logic                        alloc_hit, free_hit;
    logic [bfpa_pkg::LEN_W-1:0]  merge_len;
    logic [bfpa_pkg::ADDR_W-1:0] rem_start, grant_out;
    logic [CW+6:0]               cnt_ext;

    // Decide the fit of the entry under evaluation
    assign alloc_hit = !rd_data_reg.busy && (size_reg <= rd_data_reg.len)
                       && (!found_reg || rd_data_reg.len <= best_len_reg);
    assign free_hit  = !found_reg && rd_data_reg.busy && (rd_data_reg.start == addr_reg);

    // Build merge and split values
    assign merge_len = (pf_reg ? prev_reg.len : '0) + cur_reg.len
                       + (nf_reg ? next_reg.len : '0);
    assign rem_start = best_start_reg + size_reg[bfpa_pkg::ADDR_W-1:0];

    // Select the single table write of this cycle
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = mv_addr_reg;
        wr_data = rd_data_reg;
        if (cmd.init) begin
            wr_addr = '0;
            wr_data = '{busy: 1'b0, len: total_reg, start: '0};
        end else if (mv_d_reg) begin
            wr_addr = mv_addr_reg;
            wr_data = rd_data_reg;
        end else if (cmd.wr_rem) begin
            wr_addr = best_reg + IW'(1);
            wr_data = '{busy: 1'b0, len: best_len_reg - size_reg, start: rem_start};
        end else if (cmd.wr_grant) begin
            wr_addr = best_reg;
            wr_data = '{busy: 1'b1, len: size_reg, start: best_start_reg};
        end else if (cmd.wr_merge) begin
            wr_addr = lo_idx;
            wr_data = '{busy: 1'b0, len: merge_len,
                        start: pf_reg ? prev_reg.start : cur_reg.start};
        end else begin
            wr_en = 1'b0;
        end
    end

    // Hold the table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track the read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_d_reg <= 1'b0;
            cap_d_reg  <= 1'b0;
            mv_d_reg   <= 1'b0;
        end else begin
            scan_d_reg <= cmd.scan;
            cap_d_reg  <= cmd.cap_next;
            mv_d_reg   <= cmd.mv;
        end
        rd_idx_reg  <= rd_addr;
        mv_addr_reg <= mv_addr;
    end

    // Hold configuration and request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= bfpa_pkg::MEM_MAX;
        end else if (cfg_valid) begin
            total_reg <= (cfg_data > bfpa_pkg::MEM_MAX) ? bfpa_pkg::MEM_MAX : cfg_data;
        end
        if (cmd.take) begin
            type_reg <= s_tuser;
            size_reg <= s_tdata[33:0];
            addr_reg <= s_tdata[66:34];
        end
    end

    // Evaluate scanned entries and capture neighbours
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            pf_reg    <= 1'b0;
            nf_reg    <= 1'b0;
        end else if (cmd.scan_clr) begin
            found_reg <= 1'b0;
            pf_reg    <= 1'b0;
            nf_reg    <= 1'b0;
        end else if (scan_d_reg) begin
            if (type_reg == bfpa_pkg::REQ_ALLOC) begin
                if (alloc_hit) begin
                    found_reg      <= 1'b1;
                    best_reg       <= rd_idx_reg;
                    best_len_reg   <= rd_data_reg.len;
                    best_start_reg <= rd_data_reg.start;
                end
            end else if (free_hit) begin
                found_reg <= 1'b1;
                best_reg  <= rd_idx_reg;
                cur_reg   <= rd_data_reg;
                prev_reg  <= last_reg;
                pf_reg    <= (rd_idx_reg != '0) && !last_reg.busy;
            end
            last_reg <= rd_data_reg;
        end else if (cap_d_reg) begin
            next_reg <= rd_data_reg;
            nf_reg   <= !rd_data_reg.busy;
        end
    end

    // Load and drain the result register
    assign cnt_ext   = {7'd0, cnt};
    assign grant_out = (cmd.code == bfpa_pkg::ST_OK && type_reg == bfpa_pkg::REQ_ALLOC)
                       ? best_start_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.resp) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.resp) begin
            m_data_reg <= {5'd0, cnt_ext[6:0], grant_out, cmd.code};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign best_idx = best_reg;
    assign lo_idx   = pf_reg ? best_reg - IW'(1) : best_reg;

    assign stat.found     = found_reg;
    assign stat.exact     = (best_len_reg == size_reg);
    assign stat.size_zero = (size_reg == '0);
    assign stat.is_free   = (type_reg == bfpa_pkg::REQ_FREE);
    assign stat.k         = {1'b0, pf_reg} + {1'b0, nf_reg};
    assign stat.out_full  = m_valid_reg && !m_tready;

endmodule

### sv/bfpa_ctrl.sv
// Controller: sequences scans, shifts, updates and the result of each request.
module bfpa_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int IW = $clog2(TABLE_DEPTH),
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               s_tvalid,
    output logic               s_tready,
    output bfpa_pkg::dp_cmd_t  cmd,
    output logic [IW-1:0]      rd_addr,
    output logic [IW-1:0]      mv_addr,
    output logic [CW-1:0]      cnt,
    input  bfpa_pkg::dp_stat_t stat,
    input  logic [IW-1:0]      best_idx,
    input  logic [IW-1:0]      lo_idx
);

    localparam int XW = CW + 1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_START, S_SCAN, S_SWAIT, S_DECIDE, S_SHUP, S_SHWAIT,
        S_SPLIT, S_GRANT, S_FWAIT, S_MERGE, S_SHDN, S_SHDWAIT, S_RESP
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    code_reg, code_next;

    logic [XW-1:0] last_x, best_x, lo_src_x, ptr_x, k_x;
    logic [IW-1:0] last_idx;

    assign last_x   = XW'(cnt_reg) - XW'(1);
    assign last_idx = last_x[IW-1:0];
    assign best_x   = XW'(best_idx);
    assign k_x      = XW'(stat.k);
    assign lo_src_x = XW'(lo_idx) + XW'(1) + k_x;
    assign ptr_x    = XW'(ptr_reg);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        rd_addr    = ptr_reg;
        mv_addr    = ptr_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.init   = 1'b1;
                cnt_next   = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.scan_clr = 1'b1;
                ptr_next     = '0;
                if (!stat.is_free && stat.size_zero) begin
                    code_next  = bfpa_pkg::ST_ZERO;
                    state_next = S_RESP;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                cmd.scan  = 1'b1;
                if (ptr_reg == last_idx) begin
                    state_next = S_SWAIT;
                end else begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end
            S_SWAIT: state_next = S_DECIDE;
            S_DECIDE: begin
                if (!stat.is_free) begin
                    if (!stat.found) begin
                        code_next  = bfpa_pkg::ST_NOFIT;
                        state_next = S_RESP;
                    end else if (stat.exact) begin
                        state_next = S_GRANT;
                    end else if (XW'(cnt_reg) >= XW'(TABLE_DEPTH)) begin
                        code_next  = bfpa_pkg::ST_FULL;
                        state_next = S_RESP;
                    end else if (best_x < last_x) begin
                        ptr_next   = last_idx;
                        state_next = S_SHUP;
                    end else begin
                        state_next = S_SPLIT;
                    end
                end else begin
                    if (!stat.found) begin
                        code_next  = bfpa_pkg::ST_NOTFOUND;
                        state_next = S_RESP;
                    end else if (best_x < last_x) begin
                        cmd.rd_en    = 1'b1;
                        cmd.cap_next = 1'b1;
                        rd_addr      = best_idx + IW'(1);
                        state_next   = S_FWAIT;
                    end else begin
                        state_next = S_MERGE;
                    end
                end
            end
            S_SHUP: begin
                cmd.rd_en = 1'b1;
                cmd.mv    = 1'b1;
                mv_addr   = ptr_reg + IW'(1);
                if (ptr_x == best_x + XW'(1)) begin
                    state_next = S_SHWAIT;
                end else begin
                    ptr_next = ptr_reg - IW'(1);
                end
            end
            S_SHWAIT: state_next = S_SPLIT;
            S_SPLIT: begin
                cmd.wr_rem = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_GRANT;
            end
            S_GRANT: begin
                cmd.wr_grant = 1'b1;
                code_next    = bfpa_pkg::ST_OK;
                state_next   = S_RESP;
            end
            S_FWAIT: state_next = S_MERGE;
            S_MERGE: begin
                cmd.wr_merge = 1'b1;
                code_next    = bfpa_pkg::ST_OK;
                if (stat.k != 2'd0 && lo_src_x <= last_x) begin
                    ptr_next   = lo_src_x[IW-1:0];
                    state_next = S_SHDN;
                end else begin
                    cnt_next   = CW'(XW'(cnt_reg) - k_x);
                    state_next = S_RESP;
                end
            end
            S_SHDN: begin
                cmd.rd_en = 1'b1;
                cmd.mv    = 1'b1;
                mv_addr   = IW'(ptr_x - k_x);
                if (ptr_reg == last_idx) begin
                    state_next = S_SHDWAIT;
                end else begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end
            S_SHDWAIT: begin
                cnt_next   = CW'(XW'(cnt_reg) - k_x);
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!stat.out_full) begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
        // Restart the table on a register write
        if (cfg_valid) begin
            state_next = S_INIT;
        end
    end

    // Hold state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            ptr_reg   <= '0;
            cnt_reg   <= CW'(1);
            code_reg  <= bfpa_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cnt      = cnt_reg;

endmodule

### sv/best_fit_partition_allocator.sv
// Top level of the best-fit partition allocator.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata {req_address, req_size}, s_tuser req_type
//  m_       out  m_tvalid/m_tready    m_tdata {partitions_used, grant_address, status}
//  cfg_     in   cfg_valid/cfg_ready  cfg_data total_size
//
// One request at a time. An allocate scans every entry; on a split it moves the entries
// above the best fit up, then writes the free remainder and the grant. A free scans
// every entry, reads the right neighbour when there is one, writes the merged partition
// and moves the later entries down when the merge removes entries. A zero size is
// answered without a scan and an unknown address after it. Scans and moves go through
// the one read port of the table memory. Reset and every total_size write rebuild
// entry 0. A stalled result register holds the controller in its final state, with
// the input blocked, until the earlier transfer completes.
module best_fit_partition_allocator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [33:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // req_size[33:0], req_address[66:34], zero fill
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], grant_address[35:3], partitions_used[42:36]
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    bfpa_pkg::dp_cmd_t  cmd;
    bfpa_pkg::dp_stat_t stat;
    logic [IW-1:0]      rd_addr, mv_addr, best_idx, lo_idx;
    logic [CW-1:0]      cnt;

    assign cfg_ready = 1'b1;

    bfpa_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .mv_addr  (mv_addr),
        .cnt      (cnt),
        .stat     (stat),
        .best_idx (best_idx),
        .lo_idx   (lo_idx)
    );

    bfpa_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .mv_addr  (mv_addr),
        .cnt      (cnt),
        .stat     (stat),
        .best_idx (best_idx),
        .lo_idx   (lo_idx),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### sv/bfpa_checker.sv
// Port checker for the partition allocator, bound to the top level.
module bfpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Keep status codes in range
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= bfpa_pkg::ST_ZERO)
        else $error("status code out of range");

    // Drive a zero grant on every failed request
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != bfpa_pkg::ST_OK |-> m_tdata[35:3] == '0)
        else $error("grant address on failed request");

    // Show no result straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

### sim/best_fit_partition_allocator_checker.sv
// Checker for the partition allocator: watches the channels, predicts and compares results.
module best_fit_partition_allocator_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [33:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [6:0]                  used;
        logic [bfpa_pkg::ADDR_W-1:0] grant;
        logic [2:0]                  status;
    } reply_t;

    logic [bfpa_pkg::ADDR_W-1:0] tbl_start [TABLE_DEPTH];
    logic [bfpa_pkg::LEN_W-1:0]  tbl_len   [TABLE_DEPTH];
    logic                        tbl_busy  [TABLE_DEPTH];
    int                          tbl_count;
    reply_t                      replies_due [$];

    // Rebuild the table as one free partition
    function automatic void table_clear(logic [bfpa_pkg::LEN_W-1:0] size);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_start[i] = '0;
            tbl_len[i]   = '0;
            tbl_busy[i]  = 1'b0;
        end
        tbl_len[0] = (size > bfpa_pkg::MEM_MAX) ? bfpa_pkg::MEM_MAX : size;
        tbl_count  = 1;
    endfunction

    function automatic reply_t allocate(logic [bfpa_pkg::LEN_W-1:0] size);
        reply_t                      r;
        bit                          found;
        int                          best;
        logic [bfpa_pkg::LEN_W-1:0]  best_len;
        r = '0;
        found = 0;
        best = 0;
        best_len = '0;
        if (size == 0) begin
            r.status = bfpa_pkg::ST_ZERO;
            return r;
        end
        for (int i = 0; i < tbl_count; i++)
            if (!tbl_busy[i] && size <= tbl_len[i] && (!found || tbl_len[i] <= best_len)) begin
                found = 1;
                best = i;
                best_len = tbl_len[i];
            end
        if (!found) begin
            r.status = bfpa_pkg::ST_NOFIT;
            return r;
        end
        if (best_len != size) begin
            if (tbl_count >= TABLE_DEPTH) begin
                r.status = bfpa_pkg::ST_FULL;
                return r;
            end
            // Shift the tail up and insert the free remainder
            for (int i = tbl_count; i > best + 1; i--) begin
                tbl_start[i] = tbl_start[i-1];
                tbl_len[i]   = tbl_len[i-1];
                tbl_busy[i]  = tbl_busy[i-1];
            end
            tbl_start[best+1] = tbl_start[best] + size[bfpa_pkg::ADDR_W-1:0];
            tbl_len[best+1]   = best_len - size;
            tbl_busy[best+1]  = 1'b0;
            tbl_count++;
            tbl_len[best] = size;
        end
        tbl_busy[best] = 1'b1;
        r.status = bfpa_pkg::ST_OK;
        r.grant  = tbl_start[best];
        return r;
    endfunction

    function automatic reply_t release_part(logic [bfpa_pkg::ADDR_W-1:0] addr);
        reply_t r;
        int     idx;
        r = '0;
        idx = 0;
        while (idx < tbl_count && !(tbl_busy[idx] && tbl_start[idx] == addr))
            idx++;
        if (idx >= tbl_count) begin
            r.status = bfpa_pkg::ST_NOTFOUND;
            return r;
        end
        tbl_busy[idx] = 1'b0;
        while (idx > 0 && !tbl_busy[idx-1])
            idx--;
        // Merge each free right neighbour and close the gap
        while (idx + 1 < tbl_count && !tbl_busy[idx+1]) begin
            tbl_len[idx] = tbl_len[idx] + tbl_len[idx+1];
            for (int i = idx + 1; i + 1 < tbl_count; i++) begin
                tbl_start[i] = tbl_start[i+1];
                tbl_len[i]   = tbl_len[i+1];
                tbl_busy[i]  = tbl_busy[i+1];
            end
            tbl_count--;
        end
        r.status = bfpa_pkg::ST_OK;
        return r;
    endfunction

    // Predict on each request transfer, compare on each result transfer
    always @(posedge aclk) begin
        reply_t want, got;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            table_clear(bfpa_pkg::MEM_MAX);
            replies_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                table_clear(cfg_data);
            if (s_tvalid && s_tready) begin
                if (s_tuser == bfpa_pkg::REQ_ALLOC)
                    want = allocate(s_tdata[33:0]);
                else
                    want = release_part(s_tdata[66:34]);
                want.used = 7'(tbl_count);
                replies_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[42:0];
                if (replies_due.size() == 0) begin
                    $error("result with no request outstanding: %h", got);
                    errs++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.grant != want.grant) begin
                        $error("grant_address: expected %h, actual %h", want.grant, got.grant);
                        errs++;
                    end
                    if (got.used != want.used) begin
                        $error("partitions_used: expected %0d, actual %0d", want.used, got.used);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        pending <= replies_due.size();
    end

endmodule

### sim/best_fit_partition_allocator_test.sv
// Stimulus, clock, reset and verdict for the partition allocator testbench.
module best_fit_partition_allocator_test;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [33:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;    // req_size[33:0], req_address[66:34], zero fill
    logic        s_tuser;    // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // status[2:0], grant_address[35:3], partitions_used[42:36]
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;
    logic [bfpa_pkg::ADDR_W-1:0] granted [$];

    best_fit_partition_allocator dut (.*);
    best_fit_partition_allocator_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side stalls now and then, except in the calm stretch
    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 6);

    // Record grants so that most frees name a real partition
    always @(posedge aclk)
        if (m_tvalid && m_tready && m_tdata[2:0] == bfpa_pkg::ST_OK && m_tdata[35:3] != 0)
            granted.push_back(m_tdata[35:3]);

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("best_fit_partition_allocator_test: done, errors");
            $finish;
        end
    end

    task automatic send(logic kind, logic [33:0] size, logic [32:0] addr);
        while (!calm && $urandom_range(99) < 6)
            @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, addr, size};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_total(logic [33:0] size);
        while (pending != 0)
            @(posedge aclk);
        repeat (140) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        granted.delete();
    endtask

    // Mostly small sizes so the table fills and splits often
    function automatic logic [33:0] rand_size();
        case ($urandom_range(9))
            0:       return 34'({$urandom(), $urandom()});
            1:       return 34'($urandom_range(1, 4));
            default: return 34'($urandom_range(1, 600));
        endcase
    endfunction

    task automatic random_phase(int items);
        logic [32:0] a;
        int          k;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 55 || granted.size() == 0) begin
                send(bfpa_pkg::REQ_ALLOC, rand_size(), 33'({$urandom(), $urandom()}));
            end else if ($urandom_range(9) < 8) begin
                k = $urandom_range(granted.size() - 1);
                a = granted[k];
                granted.delete(k);
                send(bfpa_pkg::REQ_FREE, 34'({$urandom(), $urandom()}), a);
            end else begin
                send(bfpa_pkg::REQ_FREE, 34'({$urandom(), $urandom()}),
                     33'({$urandom(), $urandom()}));
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = bfpa_pkg::REQ_ALLOC;
        m_tready  = 1'b0;
        calm      = 1'b0;
        idle_cycles = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero size, whole memory, oversized, frees with merges
        send(bfpa_pkg::REQ_ALLOC, 34'd0, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'h3_FFFF_FFFF, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'd100, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'd200, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'd300, '0);
        send(bfpa_pkg::REQ_FREE, '0, 33'd100);
        send(bfpa_pkg::REQ_FREE, '0, 33'd100);
        send(bfpa_pkg::REQ_FREE, '0, 33'h1_FFFF_FFFF);
        send(bfpa_pkg::REQ_ALLOC, 34'd50, '0);
        send(bfpa_pkg::REQ_FREE, '0, 33'd0);
        send(bfpa_pkg::REQ_FREE, '0, 33'd300);
        send(bfpa_pkg::REQ_FREE, '0, 33'd50);
        send(bfpa_pkg::REQ_ALLOC, bfpa_pkg::MEM_MAX, '0);
        send(bfpa_pkg::REQ_FREE, '0, 33'd0);
        send(bfpa_pkg::REQ_ALLOC, bfpa_pkg::MEM_MAX - 34'd1, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'd1, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'd1, '0);

        // Tiny memory: exact fits, ties and a full table
        set_total(34'd70);
        for (int i = 0; i < 68; i++)
            send(bfpa_pkg::REQ_ALLOC, 34'd1, '0);
        send(bfpa_pkg::REQ_FREE, '0, 33'd10);
        send(bfpa_pkg::REQ_FREE, '0, 33'd12);
        send(bfpa_pkg::REQ_ALLOC, 34'd1, '0);
        send(bfpa_pkg::REQ_ALLOC, 34'd1, '0);

        set_total(34'd0);
        send(bfpa_pkg::REQ_ALLOC, 34'd1, '0);
        set_total(34'h3_FFFF_FFFF);
        send(bfpa_pkg::REQ_ALLOC, bfpa_pkg::MEM_MAX, '0);
        set_total(bfpa_pkg::MEM_MAX);

        calm = 1'b1;
        random_phase(200);
        calm = 1'b0;
        random_phase(300);
        set_total(34'd4000);
        random_phase(250);
        set_total(34'd1);
        random_phase(20);
        set_total(bfpa_pkg::MEM_MAX);
        random_phase(200);

        while (pending != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("best_fit_partition_allocator_test: done, clean");
        else
            $display("best_fit_partition_allocator_test: done, errors");
        $finish;
    end

endmodule
